[rtl/core/gaussian_kernel_sampled_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sampled Gaussian kernel block
// Shared forms for concurrent checks clocked on clk.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_KERNEL_SAMPLED_TOP_MACROS_SVH
`define GAUSSIAN_KERNEL_SAMPLED_TOP_MACROS_SVH

// Check that is switched off while reset is asserted.
`define GKS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define GKS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/gks_pkg.sv]
// ----------------------------------------------------------------------------
// Gaussian kernel package
// Types, constants and command codes shared by the kernel generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gks_pkg;

    localparam int MAX_TAPS_DEF = 64;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;
    localparam logic [3:0] TAYLOR_TERMS = 4'd12;
    localparam int A_LIMIT_LOG2 = 21;

    typedef struct packed {
        logic [6:0]  tap_count;
        logic [15:0] sigma_q8_8;
    } req_beat_t;

    typedef struct packed {
        logic [16:0] tap_value;
        logic        last_tap;
    } tap_beat_t;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_A,
        OP_ZERO,
        OP_DIV_K,
        OP_CAP_K,
        OP_MUL,
        OP_DIV_N,
        OP_P_UPD,
        OP_STORE,
        OP_READ,
        OP_DIV_T,
        OP_OUT,
        OP_ADV
    } dp_op_t;

    typedef struct packed {
        logic req_empty;
        logic div_done;
        logic red_done;
        logic mul_done;
        logic a_big;
        logic n_last;
        logic x_last;
        logic tap_taken;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_WAIT_A,
        ST_DIV_K,
        ST_WAIT_K,
        ST_MUL,
        ST_WAIT_MUL,
        ST_DIV_N,
        ST_WAIT_N,
        ST_UPD,
        ST_STORE,
        ST_READ,
        ST_DIV_T,
        ST_WAIT_T,
        ST_OUT,
        ST_HOLD
    } ctrl_state_t;

endpackage

[rtl/core/gaussian_kernel_sampled_top.sv]
// ----------------------------------------------------------------------------
// Sampled Gaussian kernel generator
// Builds a normalized one-dimensional Gaussian kernel in Q1.16 per request.
// ----------------------------------------------------------------------------
//   Channel  Beat fields                Handshake
//   req      tap_count, sigma_q8_8      req_valid / req_stall
//   tap      tap_value, last_tap        tap_valid / tap_stall
//
// One request is handled at a time; req_stall is high until its last tap
// beat is taken. Each sample costs a division for the exponent, a 6-step
// ln2 range reduction and twelve Horner terms of a serial multiply plus a
// division; a sample far in the tail skips the exp. Each tap then costs a
// division plus output stalls. Zero-count requests are dropped.
// Reset is asynchronous and active low; a stalled tap beat holds its value.
`timescale 1ns / 1ps

module gaussian_kernel_sampled_top #(
    parameter int MAX_TAPS = gks_pkg::MAX_TAPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  gks_pkg::req_beat_t req_data,
    output logic               tap_valid,
    input  logic               tap_stall,
    output gks_pkg::tap_beat_t tap_data
);

    localparam int XW = $clog2(MAX_TAPS + 1);
    localparam int NW = (2 * XW + 32 > 40) ? 2 * XW + 32 : 40;

    gks_pkg::dp_op_t     op;
    gks_pkg::dp_status_t status;

    // Sequencer.
    gks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .req_stall (req_stall),
        .op        (op)
    );

    // Arithmetic and storage.
    gks_datapath #(
        .MAX_TAPS (MAX_TAPS),
        .NW       (NW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .req       (req_data),
        .tap_stall (tap_stall),
        .tap_valid (tap_valid),
        .tap_data  (tap_data),
        .status    (status)
    );

endmodule

[rtl/core/gks_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division of an NW-bit numerator by a 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gks_div #(
    parameter int NW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [31:0]   den,
    output logic [NW-1:0] quo,
    output logic          done
);

    localparam int CW = $clog2(NW);

    logic [NW-1:0] quo_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [32:0]   shifted;
    logic [32:0]   diff;
    logic          ge;

    // One trial subtraction per cycle.
    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and result registers. The partial remainder stays below the
    // divisor, so it always fits in 32 bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

[rtl/core/gks_datapath.sv]
// ----------------------------------------------------------------------------
// Gaussian kernel datapath
// Sample store, running sum, exp evaluation registers, ln2 range reduction,
// serial multiplier, shared divider and output register, driven by
// controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gks_datapath #(
    parameter int MAX_TAPS = gks_pkg::MAX_TAPS_DEF,
    parameter int NW       = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gks_pkg::dp_op_t     op,
    input  gks_pkg::req_beat_t  req,
    input  logic                tap_stall,
    output logic                tap_valid,
    output gks_pkg::tap_beat_t  tap_data,
    output gks_pkg::dp_status_t status
);

    localparam int XW = $clog2(MAX_TAPS + 1);
    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    logic [XW-1:0]      cnt_reg;
    logic [XW-1:0]      x_reg;
    logic [31:0]        den_reg;
    logic [23:0]        sum_reg;
    logic [5:0]         k_reg;
    logic [31:0]        r_reg;
    logic [32:0]        p_reg;
    logic [3:0]         n_reg;
    logic [16:0]        rd_reg;
    logic [64:0]        mp_reg;
    logic [31:0]        mr_reg;
    logic [64:0]        acc_reg;
    logic [4:0]         mcnt_reg;
    logic               mbusy_reg;
    logic               mdone_reg;
    logic [37:0]        red_reg;
    logic [37:0]        lsh_reg;
    logic [5:0]         kq_reg;
    logic [2:0]         kcnt_reg;
    logic               kbusy_reg;
    logic               kdone_reg;
    logic               out_valid_reg;
    gks_pkg::tap_beat_t out_data_reg;
    logic [16:0]        mem [MAX_TAPS];

    logic [8:0]         cnt_wide;
    logic [XW-1:0]      cnt_clamp;
    logic [15:0]        sig;
    logic [XW-1:0]      mean;
    logic [XW-1:0]      tap_off;
    logic [2*XW-1:0]    dsq;
    logic               x_last;
    logic [33:0]        rnd;
    logic [16:0]        sample;
    logic [16:0]        tap;
    logic               div_start;
    logic [NW-1:0]      div_num;
    logic [31:0]        div_den;
    logic [NW-1:0]      div_q;
    logic               div_done;
    logic               taken;

    // Request decode: clamp the count, map zero sigma to the smallest step.
    assign cnt_wide  = 9'(req.tap_count);
    assign cnt_clamp = (cnt_wide > 9'(MAX_TAPS)) ? XW'(MAX_TAPS) : XW'(cnt_wide);
    assign sig       = (req.sigma_q8_8 == 16'd0) ? 16'd1 : req.sigma_q8_8;

    // Distance of the current tap from the center.
    assign mean    = cnt_reg >> 1;
    assign tap_off = (x_reg >= mean) ? (x_reg - mean) : (mean - x_reg);
    assign dsq     = tap_off * tap_off;
    assign x_last  = (x_reg == cnt_reg - 1'b1);

    // Sample rounding from the scaled exp value, and tap saturation.
    assign rnd    = 34'(p_reg >> k_reg) + 34'd32768;
    assign sample = rnd[32:16];
    assign tap    = (div_q > NW'(gks_pkg::ONE_Q16)) ? gks_pkg::ONE_Q16 : div_q[16:0];

    // Divider operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 32'd1;
        case (op)
            gks_pkg::OP_DIV_A:
            begin
                div_start = 1'b1;
                div_num   = NW'({dsq, 31'b0}) + NW'(den_reg >> 1);
                div_den   = den_reg;
            end
            gks_pkg::OP_DIV_N:
            begin
                div_start = 1'b1;
                div_num   = NW'(acc_reg[64:32]);
                div_den   = 32'(n_reg);
            end
            gks_pkg::OP_DIV_T:
            begin
                div_start = 1'b1;
                div_num   = NW'({rd_reg, 16'b0}) + NW'(sum_reg[23:1]);
                div_den   = (sum_reg == 24'd0) ? 32'd1 : 32'(sum_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    gks_div #(
        .NW(NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_q),
        .done  (div_done)
    );

    assign taken = out_valid_reg & ~tap_stall;

    // Control registers: counters, sum, multiplier, reduction and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            x_reg         <= '0;
            sum_reg       <= '0;
            n_reg         <= '0;
            mcnt_reg      <= '0;
            mbusy_reg     <= 1'b0;
            mdone_reg     <= 1'b0;
            kcnt_reg      <= '0;
            kbusy_reg     <= 1'b0;
            kdone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mdone_reg <= 1'b0;
            kdone_reg <= 1'b0;
            if (taken)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
                if (mcnt_reg == 5'd31)
                begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
            if (kbusy_reg)
            begin
                kcnt_reg <= kcnt_reg + 1'b1;
                if (kcnt_reg == 3'd5)
                begin
                    kbusy_reg <= 1'b0;
                    kdone_reg <= 1'b1;
                end
            end
            case (op)
                gks_pkg::OP_LOAD:
                begin
                    cnt_reg <= cnt_clamp;
                    x_reg   <= '0;
                    sum_reg <= '0;
                end
                gks_pkg::OP_DIV_K:
                begin
                    kcnt_reg  <= '0;
                    kbusy_reg <= 1'b1;
                end
                gks_pkg::OP_CAP_K:
                begin
                    n_reg <= gks_pkg::TAYLOR_TERMS;
                end
                gks_pkg::OP_MUL:
                begin
                    mcnt_reg  <= '0;
                    mbusy_reg <= 1'b1;
                end
                gks_pkg::OP_P_UPD:
                begin
                    n_reg <= n_reg - 1'b1;
                end
                gks_pkg::OP_STORE:
                begin
                    sum_reg <= sum_reg + 24'(sample);
                    x_reg   <= x_last ? '0 : x_reg + 1'b1;
                end
                gks_pkg::OP_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                gks_pkg::OP_ADV:
                begin
                    x_reg <= x_reg + 1'b1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (mbusy_reg)
        begin
            if (mr_reg[0])
            begin
                acc_reg <= acc_reg + mp_reg;
            end
            mp_reg <= mp_reg << 1;
            mr_reg <= mr_reg >> 1;
        end
        // Range reduction by ln2: the quotient is below 64, so six
        // compare-and-subtract steps against ln2 * 2^j give k and r.
        if (kbusy_reg)
        begin
            if (red_reg >= lsh_reg)
            begin
                red_reg <= red_reg - lsh_reg;
                kq_reg  <= {kq_reg[4:0], 1'b1};
            end
            else
            begin
                kq_reg <= {kq_reg[4:0], 1'b0};
            end
            lsh_reg <= lsh_reg >> 1;
        end
        case (op)
            gks_pkg::OP_LOAD:
            begin
                den_reg <= sig * sig;
            end
            gks_pkg::OP_ZERO:
            begin
                p_reg <= '0;
                k_reg <= '0;
            end
            gks_pkg::OP_DIV_K:
            begin
                red_reg <= {1'b0, div_q[gks_pkg::A_LIMIT_LOG2-1:0], 16'b0};
                lsh_reg <= {1'b0, gks_pkg::LN2_Q32, 5'b0};
                kq_reg  <= '0;
            end
            gks_pkg::OP_CAP_K:
            begin
                k_reg <= kq_reg;
                r_reg <= red_reg[31:0];
                p_reg <= gks_pkg::ONE_Q32;
            end
            gks_pkg::OP_MUL:
            begin
                mp_reg  <= 65'(p_reg);
                mr_reg  <= r_reg;
                acc_reg <= '0;
            end
            gks_pkg::OP_P_UPD:
            begin
                p_reg <= gks_pkg::ONE_Q32 - div_q[32:0];
            end
            gks_pkg::OP_OUT:
            begin
                out_data_reg.tap_value <= tap;
                out_data_reg.last_tap  <= x_last;
            end
            default:
            begin
                den_reg <= den_reg;
            end
        endcase
    end

    // Sample store, one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (op == gks_pkg::OP_STORE)
        begin
            mem[x_reg[AW-1:0]] <= sample;
        end
        if (op == gks_pkg::OP_READ)
        begin
            rd_reg <= mem[x_reg[AW-1:0]];
        end
    end

    assign status.req_empty = (req.tap_count == 7'd0);
    assign status.div_done  = div_done;
    assign status.red_done  = kdone_reg;
    assign status.mul_done  = mdone_reg;
    assign status.a_big     = |div_q[NW-1:gks_pkg::A_LIMIT_LOG2];
    assign status.n_last    = (n_reg == 4'd1);
    assign status.x_last    = x_last;
    assign status.tap_taken = taken;

    assign tap_valid = out_valid_reg;
    assign tap_data  = out_data_reg;

endmodule

[rtl/core/gks_ctrl.sv]
// ----------------------------------------------------------------------------
// Gaussian kernel controller
// Sequences sample generation, exp evaluation, normalization and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gks_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  gks_pkg::dp_status_t status,
    output logic                req_stall,
    output gks_pkg::dp_op_t     op
);

    gks_pkg::ctrl_state_t state_reg;
    gks_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gks_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gks_pkg::ST_IDLE:
            begin
                if (req_valid && !status.req_empty)
                begin
                    state_next = gks_pkg::ST_DIV_A;
                end
            end
            gks_pkg::ST_DIV_A:    state_next = gks_pkg::ST_WAIT_A;
            gks_pkg::ST_WAIT_A:
            begin
                if (status.div_done)
                begin
                    state_next = status.a_big ? gks_pkg::ST_STORE : gks_pkg::ST_DIV_K;
                end
            end
            gks_pkg::ST_DIV_K:    state_next = gks_pkg::ST_WAIT_K;
            gks_pkg::ST_WAIT_K:
            begin
                if (status.red_done)
                begin
                    state_next = gks_pkg::ST_MUL;
                end
            end
            gks_pkg::ST_MUL:      state_next = gks_pkg::ST_WAIT_MUL;
            gks_pkg::ST_WAIT_MUL:
            begin
                if (status.mul_done)
                begin
                    state_next = gks_pkg::ST_DIV_N;
                end
            end
            gks_pkg::ST_DIV_N:    state_next = gks_pkg::ST_WAIT_N;
            gks_pkg::ST_WAIT_N:
            begin
                if (status.div_done)
                begin
                    state_next = gks_pkg::ST_UPD;
                end
            end
            gks_pkg::ST_UPD:
            begin
                state_next = status.n_last ? gks_pkg::ST_STORE : gks_pkg::ST_MUL;
            end
            gks_pkg::ST_STORE:
            begin
                state_next = status.x_last ? gks_pkg::ST_READ : gks_pkg::ST_DIV_A;
            end
            gks_pkg::ST_READ:     state_next = gks_pkg::ST_DIV_T;
            gks_pkg::ST_DIV_T:    state_next = gks_pkg::ST_WAIT_T;
            gks_pkg::ST_WAIT_T:
            begin
                if (status.div_done)
                begin
                    state_next = gks_pkg::ST_OUT;
                end
            end
            gks_pkg::ST_OUT:      state_next = gks_pkg::ST_HOLD;
            gks_pkg::ST_HOLD:
            begin
                if (status.tap_taken)
                begin
                    state_next = status.x_last ? gks_pkg::ST_IDLE : gks_pkg::ST_READ;
                end
            end
            default:              state_next = gks_pkg::ST_IDLE;
        endcase
    end

    // Commands and input stall.
    always_comb
    begin
        op        = gks_pkg::OP_NONE;
        req_stall = 1'b1;
        case (state_reg)
            gks_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid && !status.req_empty)
                begin
                    op = gks_pkg::OP_LOAD;
                end
            end
            gks_pkg::ST_DIV_A:    op = gks_pkg::OP_DIV_A;
            gks_pkg::ST_WAIT_A:
            begin
                if (status.div_done && status.a_big)
                begin
                    op = gks_pkg::OP_ZERO;
                end
            end
            gks_pkg::ST_DIV_K:    op = gks_pkg::OP_DIV_K;
            gks_pkg::ST_WAIT_K:
            begin
                if (status.red_done)
                begin
                    op = gks_pkg::OP_CAP_K;
                end
            end
            gks_pkg::ST_MUL:      op = gks_pkg::OP_MUL;
            gks_pkg::ST_DIV_N:    op = gks_pkg::OP_DIV_N;
            gks_pkg::ST_UPD:      op = gks_pkg::OP_P_UPD;
            gks_pkg::ST_STORE:    op = gks_pkg::OP_STORE;
            gks_pkg::ST_READ:     op = gks_pkg::OP_READ;
            gks_pkg::ST_DIV_T:    op = gks_pkg::OP_DIV_T;
            gks_pkg::ST_OUT:      op = gks_pkg::OP_OUT;
            gks_pkg::ST_HOLD:
            begin
                if (status.tap_taken)
                begin
                    op = gks_pkg::OP_ADV;
                end
            end
            default:              op = gks_pkg::OP_NONE;
        endcase
    end

endmodule

[rtl/core/gks_checker.sv]
// ----------------------------------------------------------------------------
// Gaussian kernel port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gaussian_kernel_sampled_top_macros.svh"

module gks_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input gks_pkg::req_beat_t req_data,
    input logic               tap_valid,
    input logic               tap_stall,
    input gks_pkg::tap_beat_t tap_data
);

    // A stalled tap beat stays up and keeps its value.
    `GKS_ASSERT_CLK(a_tap_hold, tap_valid && tap_stall |=> tap_valid && $stable(tap_data), "tap beat changed while stalled")

    // No new request is taken while a tap beat is offered.
    `GKS_ASSERT_CLK(a_busy_stall, tap_valid |-> req_stall, "request taken during output")

    // A taken request with taps locks the input on the next cycle.
    `GKS_ASSERT_CLK(a_lock, req_valid && !req_stall && req_data.tap_count != 7'd0 |=> req_stall, "input not locked after request")

    // The last tap ends the request's output.
    `GKS_ASSERT_CLK(a_last_end, tap_valid && !tap_stall && tap_data.last_tap |=> !tap_valid, "beat after last tap")

    // Nothing is offered during reset.
    `GKS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !tap_valid, "tap valid during reset")

endmodule

bind gaussian_kernel_sampled_top gks_checker u_gks_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .tap_valid (tap_valid),
    .tap_stall (tap_stall),
    .tap_data  (tap_data)
);

[tb/sv/gaussian_kernel_sampled_top_tb.sv]
// ----------------------------------------------------------------------------
// Sampled Gaussian kernel testbench
// Sends tap-count and sigma requests, predicts each normalized Q1.16 tap in
// fixed point and checks every tap beat in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the taps still owed by the block and checks the ones it delivers.
class kernel_scoreboard;
    gks_pkg::tap_beat_t pending_taps[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // One sample of exp(-0.5*(d/sigma)^2) in Q1.16.
    function automatic logic [16:0] sample_q16(int unsigned offset, int unsigned s);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] a_q16;
        logic [63:0] big_a;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] p;
        logic [127:0] prod;
        logic [63:0] e;
        num = (64'(offset) * 64'(offset)) << 31;
        den = 64'(s) * 64'(s);
        a_q16 = (num + (den >> 1)) / den;
        if (a_q16 >= (64'd32 << 16))
            return '0;
        big_a = a_q16 << 16;
        k = big_a / 64'(gks_pkg::LN2_Q32);
        r = big_a - k * 64'(gks_pkg::LN2_Q32);
        p = 64'h1_0000_0000;
        for (int n = 12; n >= 1; n--)
        begin
            prod = 128'(p) * 128'(r);
            p = 64'h1_0000_0000 - 64'((prod >> 32) / n);
        end
        e = (k < 63) ? (p >> k) : 64'd0;
        return 17'((e + 64'd32768) >> 16);
    endfunction

    // Notes an accepted request and queues every tap it should produce.
    function void note_request(gks_pkg::req_beat_t req);
        int unsigned count;
        int unsigned s;
        int unsigned mean;
        int unsigned offset;
        logic [16:0] samples[64];
        logic [23:0] sum;
        logic [63:0] div;
        logic [63:0] t;
        gks_pkg::tap_beat_t beat;
        count = 32'(req.tap_count);
        s = 32'(req.sigma_q8_8);
        if (count == 0)
            return;
        if (count > 64)
            count = 64;
        if (s == 0)
            s = 1;
        mean = count >> 1;
        sum = '0;
        for (int unsigned x = 0; x < count; x++)
        begin
            offset = (x >= mean) ? x - mean : mean - x;
            samples[x] = sample_q16(offset, s);
            sum = sum + 24'(samples[x]);
        end
        div = (sum == 0) ? 64'd1 : 64'(sum);
        for (int unsigned x = 0; x < count; x++)
        begin
            t = (64'(samples[x]) * 64'd65536 + (div >> 1)) / div;
            if (t > 64'd65536)
                t = 64'd65536;
            beat.tap_value = t[16:0];
            beat.last_tap = (x + 1 == count);
            pending_taps = {pending_taps, beat};
        end
    endfunction

    // Compares one delivered tap beat with the oldest expected one.
    function void check_tap(gks_pkg::tap_beat_t got);
        gks_pkg::tap_beat_t want;
        if (pending_taps.size() == 0)
        begin
            report("unexpected tap beat", 0, got.tap_value);
            return;
        end
        want = pending_taps.pop_front();
        if (got.tap_value !== want.tap_value)
            report("tap_value", want.tap_value, got.tap_value);
        if (got.last_tap !== want.last_tap)
            report("last_tap", want.last_tap, got.last_tap);
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        errors++;
    endfunction
endclass

module gaussian_kernel_sampled_top_tb;

    // A full 64-tap request computes all its samples with nothing accepted.
    localparam int IDLE_LIMIT = 400000;
    localparam int RANDOM_REQUESTS = 280;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    gks_pkg::req_beat_t req_data;
    logic tap_valid;
    logic tap_stall;
    gks_pkg::tap_beat_t tap_data;

    kernel_scoreboard board;
    int idle_cycles;
    int burst_left;

    gaussian_kernel_sampled_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .tap_valid(tap_valid),
        .tap_stall(tap_stall),
        .tap_data(tap_data)
    );

    // Free-running clock, 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver stalls on its own pattern: quiet stretches and busy ones.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tap_stall <= 1'b0;
        else if ((($time / 20) % 400) < 150)
            tap_stall <= 1'b0;
        else
            tap_stall <= ($urandom_range(0, 3) == 0);
    end

    // Check every accepted tap beat and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tap_valid && !tap_stall)
                board.check_tap(tap_data);
            if ((tap_valid && !tap_stall) || (req_valid && !req_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Sends one request beat, with a random gap between bursts.
    task automatic send_request(input logic [6:0] count, input logic [15:0] sigma);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 5);
        end
        req_valid <= 1'b1;
        req_data <= '{tap_count: count, sigma_q8_8: sigma};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request('{tap_count: count, sigma_q8_8: sigma});
        burst_left--;
    endtask

    initial
    begin
        logic [6:0] cnt;
        logic [15:0] sig;
        board = new();
        idle_cycles = 0;
        burst_left = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero count, clamping, zero sigma and field extremes.
        send_request(7'd0, 16'd256);
        send_request(7'd1, 16'd256);
        send_request(7'd2, 16'd1);
        send_request(7'd64, 16'd0);
        send_request(7'd127, 16'd256);
        send_request(7'd65, 16'hFFFF);
        send_request(7'd64, 16'd1);
        send_request(7'd5, 16'hAAAA);
        send_request(7'd7, 16'h5555);
        send_request(7'd9, 16'd128);
        send_request(7'd33, 16'd768);
        send_request(7'd96, 16'd4096);
        send_request(7'd3, 16'h8000);

        // Random: mostly small kernels, a few large ones and odd counts.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            case ($urandom_range(0, 9))
                0: cnt = 7'($urandom_range(0, 127));
                1: cnt = 7'($urandom_range(32, 64));
                default: cnt = 7'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 3))
                0: sig = 16'($urandom_range(0, 65535));
                1: sig = 16'($urandom_range(0, 255));
                default: sig = 16'($urandom_range(128, 2047));
            endcase
            send_request(cnt, sig);
        end
        req_valid <= 1'b0;

        // Drain the outstanding taps, then a short settle time.
        while (board.pending_taps.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[gaussian_kernel_sampled_top.f]
+incdir+rtl/core
rtl/core/gks_pkg.sv
rtl/core/gks_div.sv
rtl/core/gks_datapath.sv
rtl/core/gks_ctrl.sv
rtl/core/gaussian_kernel_sampled_top.sv
rtl/core/gks_checker.sv
tb/sv/gaussian_kernel_sampled_top_tb.sv
